[src/gtb_pkg.sv]
// Shared constants, codes and types of the timed sample gate.
`default_nettype none

package gtb_pkg;

  localparam int unsigned RING_DEPTH_DEF  = 32;
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned SMP_W           = 16;
  localparam int unsigned TIME_W          = 32;
  localparam int unsigned CAP_W           = 6;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned CFG_DATA_W      = 32;

  localparam logic [TIME_W-1:0] WINDOW_RESET   = 32'd900;
  localparam logic [CAP_W-1:0]  CAPACITY_RESET = 6'd32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BUFFER_ENABLE   = 2'd0,
    CFG_WINDOW_LENGTH   = 2'd1,
    CFG_BUFFER_CAPACITY = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    ACT_DATA = 1'b0,
    ACT_OPEN = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_FLUSH = 2'b10
  } gate_state_t;

  // Ring pointer commands: push stores at the tail, pop advances the head.
  typedef struct packed {
    logic push;
    logic pop;
  } ring_cmd_t;

endpackage

`default_nettype wire

[src/gtb_ring_mem.sv]
// Sample ring storage: one write port, one registered read port.
`default_nettype none

module gtb_ring_mem #(
  parameter int unsigned DEPTH  = gtb_pkg::RING_DEPTH_DEF,
  parameter int unsigned DATA_W = 2 * gtb_pkg::SAMPLE_BITS_DEF,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] ring_r [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_r[wr_addr] <= wr_data;
    end
  end

  // Hold read data until the next read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= ring_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[src/gtb_ring_ctrl.sv]
// Ring head and fill count, with overwrite of the oldest entry when full.
`default_nettype none

module gtb_ring_ctrl #(
  parameter int unsigned DEPTH = gtb_pkg::RING_DEPTH_DEF,
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire gtb_pkg::ring_cmd_t        cmd,
  input  wire logic [gtb_pkg::CAP_W-1:0] capacity,
  output logic      [PTR_W-1:0]          wr_addr,
  output logic      [PTR_W-1:0]          rd_addr,
  output logic      [CNT_W-1:0]          count
);

  import gtb_pkg::*;

  localparam int unsigned SUM_W = CNT_W + 1;

  logic [PTR_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] cap_eff;
  logic [CAP_W:0]   cap_ext;
  logic [PTR_W-1:0] tail;

  // Fold a sum below twice the depth back into the ring.
  function automatic logic [PTR_W-1:0] wrap(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] d;
    d = SUM_W'(DEPTH);
    if (s >= d) begin
      return PTR_W'(s - d);
    end
    return PTR_W'(s);
  endfunction

  // Clamp capacity into 1..DEPTH.
  always_comb begin
    cap_ext = {1'b0, capacity};
    if (capacity == '0) begin
      cap_eff = CNT_W'(1);
    end else if (cap_ext > (CAP_W + 1)'(DEPTH)) begin
      cap_eff = CNT_W'(DEPTH);
    end else begin
      cap_eff = CNT_W'(capacity);
    end
  end

  assign tail = wrap(SUM_W'(head_r) + SUM_W'(count_r));

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (cmd.push) begin
      if (count_r >= cap_eff) begin
        // Drop the oldest entries until one place is free.
        head_nxt  = wrap(SUM_W'(head_r) + SUM_W'(count_r) - SUM_W'(cap_eff) + SUM_W'(1));
        count_nxt = cap_eff;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end else if (cmd.pop) begin
      head_nxt  = wrap(SUM_W'(head_r) + SUM_W'(1));
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  assign wr_addr = tail;
  assign rd_addr = head_r;
  assign count   = count_r;

endmodule

`default_nettype wire

[src/timed_gate_with_buffer.sv]
// Top level of the timed sample gate with a ring buffer for the closed state.
// Flow: a passing item is held while the ring drains; its buffered samples load the output
//   oldest first, each after a registered ring read, and the item's own sample follows, marked last.
// Stalls: an item without results never stalls the input; a passing item stalls it until its
//   own sample is loaded, and a stalled result holds the flush back.
// Reset (synchronous, rst_n low): gate closed, stamp 0, ring empty, registers at defaults.
`default_nettype none

module timed_gate_with_buffer #(
  parameter int unsigned RING_DEPTH  = gtb_pkg::RING_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS = gtb_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Input requests
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_action,
  input  wire logic        [gtb_pkg::TIME_W-1:0] in_now_ms,
  input  wire logic        [gtb_pkg::TIME_W-1:0] in_open_stamp_ms,
  input  wire logic signed [gtb_pkg::SMP_W-1:0]  in_real,
  input  wire logic signed [gtb_pkg::SMP_W-1:0]  in_imag,
  // Result requests
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed      [gtb_pkg::SMP_W-1:0]  out_real,
  output logic signed      [gtb_pkg::SMP_W-1:0]  out_imag,
  output logic                                   out_last,
  // Register writes
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic     [gtb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic    [gtb_pkg::CFG_DATA_W-1:0] cfg_data
);

  import gtb_pkg::*;

  // Samples are kept in their low bits only; anything above 16 bits adds nothing.
  localparam int unsigned HOLD_W = (SAMPLE_BITS < SMP_W) ? SAMPLE_BITS : SMP_W;
  localparam int unsigned PTR_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(RING_DEPTH + 1);

  // Configuration registers
  logic              buffer_enable_r, buffer_enable_nxt;
  logic [TIME_W-1:0] window_length_r, window_length_nxt;
  logic [CAP_W-1:0]  buffer_capacity_r, buffer_capacity_nxt;

  // Gate state
  gate_state_t       state_r, state_nxt;
  logic              gate_open_r, gate_open_nxt;
  logic [TIME_W-1:0] opened_at_r, opened_at_nxt;

  // Passing item, held while the ring drains
  logic [SMP_W-1:0]  item_real_r, item_real_nxt;
  logic [SMP_W-1:0]  item_imag_r, item_imag_nxt;

  // Output register and ring read-data status
  logic              out_valid_r, out_valid_nxt;
  logic              out_last_r, out_last_nxt;
  logic [SMP_W-1:0]  out_real_r, out_real_nxt;
  logic [SMP_W-1:0]  out_imag_r, out_imag_nxt;
  logic              rd_valid_r, rd_valid_nxt;

  // Datapath
  logic              in_accept;
  logic              cfg_write;
  logic              is_open_evt;
  logic [TIME_W-1:0] base_stamp;
  logic [TIME_W-1:0] elapsed;
  logic              expired;
  logic              out_free;
  logic              move;
  logic              finish;
  logic [SMP_W-1:0]  masked_real;
  logic [SMP_W-1:0]  masked_imag;
  logic [SMP_W-1:0]  held_real;
  logic [SMP_W-1:0]  held_imag;

  ring_cmd_t               ring_cmd;
  logic [PTR_W-1:0]        wr_addr;
  logic [PTR_W-1:0]        rd_addr;
  logic [CNT_W-1:0]        ring_count;
  logic [2*HOLD_W-1:0]     rd_data;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // Expiry: wrapping difference against the stamp in force for this item.
  // An open event judges against its own stamp.
  assign is_open_evt = (action_t'(in_action) == ACT_OPEN);
  assign base_stamp  = is_open_evt ? in_open_stamp_ms : opened_at_r;
  assign elapsed     = in_now_ms - base_stamp;
  assign expired     = (elapsed > window_length_r);

  assign masked_real = SMP_W'(in_real[HOLD_W-1:0]);
  assign masked_imag = SMP_W'(in_imag[HOLD_W-1:0]);
  assign held_real   = SMP_W'(rd_data[2*HOLD_W-1:HOLD_W]);
  assign held_imag   = SMP_W'(rd_data[HOLD_W-1:0]);

  // Flush handshake: the output register takes a value when empty or being drained.
  assign out_free = !out_valid_r || !out_stall;
  assign move     = (state_r == ST_FLUSH) && rd_valid_r && out_free;
  assign finish   = (state_r == ST_FLUSH) && (ring_count == '0) && !rd_valid_r && out_free;

  // Ring commands: store on closed or closing gate if enabled; flush pops one a cycle if unstalled.
  always_comb begin
    ring_cmd.push = in_accept && !is_open_evt && buffer_enable_r && (!gate_open_r || expired);
    ring_cmd.pop  = (state_r == ST_FLUSH) && (ring_count != '0) && (!rd_valid_r || move);
  end

  // Configuration writes
  always_comb begin
    buffer_enable_nxt   = buffer_enable_r;
    window_length_nxt   = window_length_r;
    buffer_capacity_nxt = buffer_capacity_r;
    if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        CFG_BUFFER_ENABLE:   buffer_enable_nxt   = cfg_data[0];
        CFG_WINDOW_LENGTH:   window_length_nxt   = cfg_data[TIME_W-1:0];
        CFG_BUFFER_CAPACITY: buffer_capacity_nxt = cfg_data[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Gate decisions on accepted requests, flush sequencing otherwise
  always_comb begin
    state_nxt     = state_r;
    gate_open_nxt = gate_open_r;
    opened_at_nxt = opened_at_r;
    item_real_nxt = item_real_r;
    item_imag_nxt = item_imag_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (is_open_evt) begin
            // The stamp is kept even when the window has already run out.
            opened_at_nxt = in_open_stamp_ms;
            if (!expired) begin
              gate_open_nxt = 1'b1;
            end
          end else if (gate_open_r) begin
            if (expired) begin
              gate_open_nxt = 1'b0;
            end else begin
              // Hold the item and drain the ring ahead of it.
              item_real_nxt = masked_real;
              item_imag_nxt = masked_imag;
              state_nxt     = ST_FLUSH;
            end
          end
        end
      end
      ST_FLUSH: begin
        if (finish) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output register and read-data tracking
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_last_nxt  = out_last_r;
    out_real_nxt  = out_real_r;
    out_imag_nxt  = out_imag_r;
    rd_valid_nxt  = rd_valid_r;

    if (ring_cmd.pop) begin
      rd_valid_nxt = 1'b1;
    end else if (move) begin
      rd_valid_nxt = 1'b0;
    end

    if (move) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = 1'b0;
      out_real_nxt  = held_real;
      out_imag_nxt  = held_imag;
    end else if (finish) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = 1'b1;
      out_real_nxt  = item_real_r;
      out_imag_nxt  = item_imag_r;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buffer_enable_r   <= 1'b0;
      window_length_r   <= WINDOW_RESET;
      buffer_capacity_r <= CAPACITY_RESET;
      state_r           <= ST_IDLE;
      gate_open_r       <= 1'b0;
      opened_at_r       <= '0;
      out_valid_r       <= 1'b0;
      rd_valid_r        <= 1'b0;
    end else begin
      buffer_enable_r   <= buffer_enable_nxt;
      window_length_r   <= window_length_nxt;
      buffer_capacity_r <= buffer_capacity_nxt;
      state_r           <= state_nxt;
      gate_open_r       <= gate_open_nxt;
      opened_at_r       <= opened_at_nxt;
      out_valid_r       <= out_valid_nxt;
      rd_valid_r        <= rd_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    item_real_r <= item_real_nxt;
    item_imag_r <= item_imag_nxt;
    out_last_r  <= out_last_nxt;
    out_real_r  <= out_real_nxt;
    out_imag_r  <= out_imag_nxt;
  end

  gtb_ring_ctrl #(
    .DEPTH (RING_DEPTH)
  ) u_ring_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (ring_cmd),
    .capacity (buffer_capacity_r),
    .wr_addr  (wr_addr),
    .rd_addr  (rd_addr),
    .count    (ring_count)
  );

  gtb_ring_mem #(
    .DEPTH  (RING_DEPTH),
    .DATA_W (2 * HOLD_W)
  ) u_ring_mem (
    .clk     (clk),
    .wr_en   (ring_cmd.push),
    .wr_addr (wr_addr),
    .wr_data ({in_real[HOLD_W-1:0], in_imag[HOLD_W-1:0]}),
    .rd_en   (ring_cmd.pop),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_valid = out_valid_r;
  assign out_last  = out_last_r;
  assign out_real  = out_real_r;
  assign out_imag  = out_imag_r;

endmodule

`default_nettype wire

[src/gtb_checker.sv]
// Port-level checks of the timed sample gate, bound to the top level.
`default_nettype none

module gtb_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] out_real,
  input wire logic [15:0] out_imag,
  input wire logic        out_last
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_real) && $stable(out_imag)
                               && $stable(out_last))
    else $error("result changed while stalled");

  // No result leaves reset.
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // A non-final result means the flush is still running, so input waits.
  a_flush_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> in_stall)
    else $error("input open while a flush result is pending");

  // Input opens again only once the final result of a flush is loaded.
  a_release_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(in_stall) |-> out_valid && out_last)
    else $error("input released without a final result");

endmodule

bind timed_gate_with_buffer gtb_checker u_gtb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_real  (out_real),
  .out_imag  (out_imag),
  .out_last  (out_last)
);

`default_nettype wire
